// ===== rtl/core/csa_pkg.sv =====
// Types and constants shared by the colour sensor auto-range block.
`default_nettype none

package csa_pkg;

   localparam int START_TIME_CODE_DEF = 8;
   localparam int CEIL_TIME_CODE_DEF  = 9;
   localparam int FULL_TIME_CODE_DEF  = 10;
   localparam int MAX_TRIES_DEF       = 4;

   localparam logic [2:0] STATUS_REMEASURE = 3'd0;
   localparam logic [2:0] STATUS_OK        = 3'd1;
   localparam logic [2:0] STATUS_ADDR      = 3'd2;
   localparam logic [2:0] STATUS_REG       = 3'd3;
   localparam logic [2:0] STATUS_TIMEOUT   = 3'd4;

   localparam logic [1:0] FAULT_NONE    = 2'd0;
   localparam logic [1:0] FAULT_ADDR    = 2'd1;
   localparam logic [1:0] FAULT_REG     = 2'd2;
   localparam logic [1:0] FAULT_TIMEOUT = 2'd3;

   typedef struct packed {
      logic [15:0] reading_x;
      logic [15:0] reading_y;
      logic [15:0] reading_z;
      logic [1:0]  bus_fault;
   } csa_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  time_code;
      logic [1:0]  current_code;
      logic [30:0] scaled_x;
      logic [30:0] scaled_y;
      logic [30:0] scaled_z;
   } csa_rsp_type;

   typedef struct packed {
      logic [3:0] time_setting;
      logic [1:0] current_setting;
      logic [1:0] try_count;
   } csa_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/csa_eval.sv =====
// Range check, code update and channel scaling for one measurement.
`default_nettype none

module csa_eval
   import csa_pkg::*;
#(
   parameter int START_TIME_CODE = START_TIME_CODE_DEF,
   parameter int CEIL_TIME_CODE  = CEIL_TIME_CODE_DEF,
   parameter int FULL_TIME_CODE  = FULL_TIME_CODE_DEF,
   parameter int MAX_TRIES       = MAX_TRIES_DEF
) (
   input  wire csa_req_type   req,
   input  wire csa_state_type state,
   output csa_state_type state_next,
   output csa_rsp_type   rsp
);

   function automatic logic [30:0] scale(input logic [15:0] raw, input logic [4:0] sh,
                                         input logic [6:0] k);
      logic [22:0] prod;
      logic [43:0] wide;
      begin
         prod = 23'(raw) * 23'(k);
         wide = 44'(prod) << sh;
         scale = (|wide[43:31]) ? 31'h7fffffff : wide[30:0];
      end
   endfunction

   csa_state_type restart;
   logic [4:0]  tp10;
   logic [16:0] full_wide;
   logic [15:0] full;
   logic [15:0] eighth;
   logic [15:0] upper;
   logic        all_low;
   logic        any_high;
   logic [4:0]  t_raise;
   logic [3:0]  t_adj;
   logic [1:0]  c_adj;
   logic        adjusted;
   logic [2:0]  tries_next;
   logic        done;
   logic [3:0]  full_code;
   logic [3:0]  time_diff;
   logic [4:0]  shift;

   always_comb begin
      restart.time_setting    = 4'(START_TIME_CODE);
      restart.current_setting = 2'd0;
      restart.try_count       = 2'd0;

      tp10      = {1'b0, state.time_setting} + 5'd10;
      full_wide = (17'd1 << tp10[3:0]) - 17'd1;
      full      = (tp10 >= 5'd16) ? 16'hffff : full_wide[15:0];
      eighth    = full >> 3;
      upper     = full - eighth;
      all_low   = (req.reading_x < eighth) && (req.reading_y < eighth)
                  && (req.reading_z < eighth);
      any_high  = (req.reading_x >= upper) || (req.reading_y >= upper)
                  || (req.reading_z >= upper);

      t_raise = {1'b0, state.time_setting} + 5'd2;
      if (t_raise > 5'(CEIL_TIME_CODE)) begin
         t_raise = 5'(CEIL_TIME_CODE);
      end
      if (t_raise > 5'd15) begin
         t_raise = 5'd15;
      end

      t_adj    = state.time_setting;
      c_adj    = state.current_setting;
      adjusted = 1'b0;
      priority if (all_low) begin
         t_adj    = t_raise[3:0];
         adjusted = 1'b1;
      end else if (any_high) begin
         c_adj    = (state.current_setting == 2'd3) ? 2'd3 : state.current_setting + 2'd1;
         adjusted = 1'b1;
      end

      tries_next = {1'b0, state.try_count} + 3'd1;
      done       = !adjusted || (tries_next >= 3'(MAX_TRIES));

      full_code = 4'(FULL_TIME_CODE);
      time_diff = (full_code > t_adj) ? full_code - t_adj : 4'd0;
      shift     = {1'b0, time_diff} + {2'b00, c_adj, 1'b0};

      rsp.scaled_x     = 31'd0;
      rsp.scaled_y     = 31'd0;
      rsp.scaled_z     = 31'd0;
      rsp.time_code    = restart.time_setting;
      rsp.current_code = restart.current_setting;
      state_next       = restart;

      if (req.bus_fault != FAULT_NONE) begin
         unique case (req.bus_fault)
            FAULT_ADDR:    rsp.status = STATUS_ADDR;
            FAULT_REG:     rsp.status = STATUS_REG;
            FAULT_TIMEOUT: rsp.status = STATUS_TIMEOUT;
            default:       rsp.status = STATUS_OK;
         endcase
      end else if (!done) begin
         rsp.status                 = STATUS_REMEASURE;
         rsp.time_code              = t_adj;
         rsp.current_code           = c_adj;
         state_next.time_setting    = t_adj;
         state_next.current_setting = c_adj;
         state_next.try_count       = tries_next[1:0];
      end else begin
         rsp.status   = STATUS_OK;
         rsp.scaled_x = scale(req.reading_x, shift, 7'd33);
         rsp.scaled_y = scale(req.reading_y, shift, 7'd32);
         rsp.scaled_z = scale(req.reading_z, shift, 7'd69);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/colour_sensor_autorange.sv =====
// Colour sensor auto-range controller, top level.
//
// req_ channel: one three-channel measurement per transfer, taken with the
// codes reported on the previous result, plus the bus fault code of that
// measurement. rsp_ channel: one result per request: a remeasure request
// with new time and current codes, a final scaled reading, or a fault.
// A request is registered, evaluated against the held codes and try count,
// and its result lands in the output register, which drives rsp_valid. One
// request per cycle is sustained while rsp_stall is low; the held codes
// update as each result is written, so the next request, even in the
// following cycle, sees them.
// When rsp_stall is high the result holds, the input register keeps at most
// one more request, and req_stall rises only when both are occupied.
// Reset empties both registers and sets the start time code, current code
// zero and try count zero. Each final result restores the same codes.
`default_nettype none

module colour_sensor_autorange
   import csa_pkg::*;
#(
   parameter int START_TIME_CODE = START_TIME_CODE_DEF,
   parameter int CEIL_TIME_CODE  = CEIL_TIME_CODE_DEF,
   parameter int FULL_TIME_CODE  = FULL_TIME_CODE_DEF,
   parameter int MAX_TRIES       = MAX_TRIES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_stall,
   input  wire csa_req_type req_data,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output csa_rsp_type rsp_data
);

   logic          in_valid_ff, in_valid_in;
   csa_req_type   in_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   csa_rsp_type   rsp_data_ff;
   csa_state_type state_ff;
   csa_state_type state_next;
   csa_rsp_type   rsp_in;
   logic          advance;
   logic          req_take;

   csa_eval #(
      .START_TIME_CODE (START_TIME_CODE),
      .CEIL_TIME_CODE  (CEIL_TIME_CODE),
      .FULL_TIME_CODE  (FULL_TIME_CODE),
      .MAX_TRIES       (MAX_TRIES)
   ) u_eval (
      .req        (in_data_ff),
      .state      (state_ff),
      .state_next (state_next),
      .rsp        (rsp_in)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         state_ff.time_setting    <= 4'(START_TIME_CODE);
         state_ff.current_setting <= 2'd0;
         state_ff.try_count       <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // final results restart the run
   assert property (@(posedge clock) disable iff (reset)
      advance && (rsp_in.status != STATUS_REMEASURE) |=>
         (state_ff.time_setting == 4'(START_TIME_CODE)) &&
         (state_ff.current_setting == 2'd0) && (state_ff.try_count == 2'd0))
      else $error("codes not restored after final result");

   assert property (@(posedge clock) disable iff (reset)
      advance && (rsp_in.status == STATUS_REMEASURE) |=>
         (state_ff.try_count == $past(state_ff.try_count) + 2'd1))
      else $error("try count not advanced on remeasure");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("held request lost");

   assert property (@(posedge clock) disable iff (reset)
      3'({1'b0, state_ff.try_count}) < 3'(MAX_TRIES))
      else $error("try count beyond limit");

endmodule

`default_nettype wire
